>>> rtl/core/kmst_pkg.sv
package kmst_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;

	localparam int VID_W  = $clog2(MAX_VERTICES);
	localparam int EIDX_W = $clog2(MAX_EDGES);
	localparam int ECNT_W = $clog2(MAX_EDGES + 1);
	localparam int VC_W   = 7;
	localparam int KEY_W  = 32 + EIDX_W;

	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef struct packed {
		logic [5:0]         edge_source;
		logic [5:0]         edge_target;
		logic signed [31:0] edge_weight;
		logic               final_edge;
	} edge_in_t;

	typedef struct packed {
		logic [5:0]         tree_source;
		logic [5:0]         tree_target;
		logic signed [31:0] tree_weight;
		logic signed [39:0] running_total;
		logic               edge_present;
		logic               run_end;
		logic               input_dropped;
	} tree_out_t;

	typedef struct packed {
		logic [5:0]  src;
		logic [5:0]  dst;
		logic [31:0] w;
	} edge_rec_t;

	typedef struct packed {
		logic             wr_en;
		logic [VID_W-1:0] wr_addr;
		logic [VID_W-1:0] wr_data;
		logic [VID_W-1:0] rd_addr;
		logic             clear;
	} pt_ctrl_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_PASS,
		ST_SCAN,
		ST_EVAL,
		ST_RA_RD,
		ST_RA_CHK,
		ST_RB_RD,
		ST_RB_CHK,
		ST_UNION,
		ST_EMIT,
		ST_FINISH
	} kmst_state_t;

endpackage

>>> rtl/core/kruskal_minimum_spanning_tree.sv
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   in_data  (edge_in_t)
// out       out  out_valid / out_ready out_data (tree_out_t)
// cfg       in   psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// loading: one edge request per cycle; in-range edges go to the edge memory until full
// run: per examined edge one pass over the edge memory
//   finds the next edge in (weight, arrival) order, then root walks
//   follow the parent links from both end vertices
// in_ready is low from the final edge until the last result is registered
// reset is asynchronous; the parent table clears at once through its link bits
// out_ready low stalls the run when a result must move into an output slot still held
module kruskal_minimum_spanning_tree (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kmst_pkg::edge_in_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output kmst_pkg::tree_out_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import kmst_pkg::*;

	kmst_state_t state_q, state_d;

	logic [VC_W-1:0]   vc_q, vc_act;
	logic [ECNT_W-1:0] etot_q, cnt_q;
	logic              drop_q;
	logic [VC_W-1:0]   kept_q;
	logic [39:0]       sum_q, sum_new;
	logic              rdv_s1;
	logic [EIDX_W-1:0] idx_s1;
	logic              best_v_q, last_v_q;
	logic [KEY_W-1:0]  best_key_q, last_key_q, key_c;
	edge_rec_t         best_rec_q, erd, ewr;
	logic [VID_W-1:0]  v_q, ra_q;
	logic              pend_v_q, out_v_q;
	tree_out_t         pend_q, nres_q, out_q;
	tree_out_t         last_res;
	logic              out_load;

	logic       acc_in, bad_in, out_free, more_ok, range_bad;
	logic       root_s1;
	logic [VID_W-1:0] parent_s1;
	pt_ctrl_t   pt_ctrl;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {{(32-VC_W){1'b0}}, vc_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_W'(MAX_VERTICES);
		end else if (psel && penable && pwrite && paddr[2] == REG_VERTEX_COUNT) begin
			vc_q <= pwdata[VC_W-1:0];
		end
	end

	// zero acts as one, oversize clamps to the table size
	always_comb begin
		if (vc_q == '0) begin
			vc_act = VC_W'(1);
		end else if (vc_q > VC_W'(MAX_VERTICES)) begin
			vc_act = VC_W'(MAX_VERTICES);
		end else begin
			vc_act = vc_q;
		end
	end

	assign in_ready  = (state_q == ST_LOAD);
	assign acc_in    = in_valid && in_ready;
	assign bad_in    = ({1'b0, in_data.edge_source} >= vc_act)
		|| ({1'b0, in_data.edge_target} >= vc_act)
		|| (etot_q >= ECNT_W'(MAX_EDGES));
	assign out_free  = !out_v_q || out_ready;
	assign more_ok   = ({1'b0, kept_q} + 8'd1) < {1'b0, vc_act};
	assign range_bad = ({1'b0, best_rec_q.src} >= vc_act)
		|| ({1'b0, best_rec_q.dst} >= vc_act);

	// output slot loads on a held result moving out or on the run's last item
	assign out_load  = out_free && ((state_q == ST_EMIT && pend_v_q) || state_q == ST_FINISH);

	// last item of the run: held result or the empty item, marked as run end
	always_comb begin
		if (pend_v_q) begin
			last_res = pend_q;
		end else begin
			last_res = '0;
			last_res.input_dropped = drop_q;
		end
		last_res.run_end = 1'b1;
	end

	assign ewr = '{src: in_data.edge_source, dst: in_data.edge_target,
		w: in_data.edge_weight};

	kmst_edge_store u_store (
		.clk     (clk),
		.wr_en   (acc_in && !bad_in),
		.wr_addr (etot_q[EIDX_W-1:0]),
		.wr_data (ewr),
		.rd_addr (cnt_q[EIDX_W-1:0]),
		.rd_data (erd)
	);

	always_comb begin
		pt_ctrl.wr_en   = (state_q == ST_UNION);
		pt_ctrl.wr_addr = ra_q;
		pt_ctrl.wr_data = v_q;
		pt_ctrl.rd_addr = v_q;
		pt_ctrl.clear   = (state_q == ST_FINISH) && out_free;
	end

	kmst_parent_table u_parent (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (pt_ctrl),
		.root_s1   (root_s1),
		.parent_s1 (parent_s1)
	);

	// sort key: sign-flipped weight, arrival index breaks ties
	assign key_c   = {~erd.w[31], erd.w[30:0], idx_s1};
	assign sum_new = sum_q + {{8{best_rec_q.w[31]}}, best_rec_q.w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (acc_in && in_data.final_edge) state_d = ST_PASS;
			end
			ST_PASS: begin
				state_d = more_ok ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				if (cnt_q == etot_q && !rdv_s1) state_d = best_v_q ? ST_EVAL : ST_FINISH;
			end
			ST_EVAL: begin
				state_d = range_bad ? ST_PASS : ST_RA_RD;
			end
			ST_RA_RD:  state_d = ST_RA_CHK;
			ST_RA_CHK: state_d = root_s1 ? ST_RB_RD : ST_RA_RD;
			ST_RB_RD:  state_d = ST_RB_CHK;
			ST_RB_CHK: begin
				if (!root_s1) begin
					state_d = ST_RB_RD;
				end else begin
					state_d = (v_q == ra_q) ? ST_PASS : ST_UNION;
				end
			end
			ST_UNION: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!pend_v_q || out_free) state_d = ST_PASS;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// run control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			etot_q   <= '0;
			drop_q   <= 1'b0;
			kept_q   <= '0;
			sum_q    <= '0;
			cnt_q    <= '0;
			rdv_s1   <= 1'b0;
			best_v_q <= 1'b0;
			last_v_q <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			rdv_s1 <= (state_q == ST_SCAN) && (cnt_q != etot_q);
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (acc_in) begin
						if (bad_in) drop_q <= 1'b1;
						else etot_q <= etot_q + ECNT_W'(1);
					end
				end
				ST_PASS: begin
					cnt_q    <= '0;
					best_v_q <= 1'b0;
				end
				ST_SCAN: begin
					if (cnt_q != etot_q) begin
						cnt_q  <= cnt_q + ECNT_W'(1);
					end
					if (rdv_s1 && (!last_v_q || key_c > last_key_q)
						&& (!best_v_q || key_c < best_key_q)) begin
						best_v_q <= 1'b1;
					end
					if (cnt_q == etot_q && !rdv_s1) last_v_q <= best_v_q;
				end
				ST_UNION: begin
					kept_q <= kept_q + VC_W'(1);
					sum_q  <= sum_new;
				end
				ST_EMIT: begin
					if (!pend_v_q) begin
						pend_v_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						etot_q   <= '0;
						drop_q   <= 1'b0;
						kept_q   <= '0;
						sum_q    <= '0;
						last_v_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[EIDX_W-1:0];
		unique case (state_q)
			ST_SCAN: begin
				if (rdv_s1 && (!last_v_q || key_c > last_key_q)
					&& (!best_v_q || key_c < best_key_q)) begin
					best_key_q <= key_c;
					best_rec_q <= erd;
				end
				if (cnt_q == etot_q && !rdv_s1) last_key_q <= best_key_q;
			end
			ST_EVAL: v_q <= best_rec_q.src[VID_W-1:0];
			ST_RA_CHK: begin
				if (root_s1) begin
					ra_q <= v_q;
					v_q  <= best_rec_q.dst[VID_W-1:0];
				end else begin
					v_q <= parent_s1;
				end
			end
			ST_RB_CHK: begin
				if (!root_s1) v_q <= parent_s1;
			end
			ST_UNION: begin
				nres_q <= '{tree_source: best_rec_q.src, tree_target: best_rec_q.dst,
					tree_weight: best_rec_q.w, running_total: sum_new,
					edge_present: 1'b1, run_end: 1'b0, input_dropped: drop_q};
			end
			ST_EMIT: begin
				if (!pend_v_q) begin
					pend_q <= nres_q;
				end else if (out_free) begin
					out_q  <= pend_q;
					pend_q <= nres_q;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_q <= last_res;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// checks
	a_empty_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.edge_present |-> out_data.run_end)
		else $error("empty result without run end");

	a_no_pending_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |-> !pend_v_q)
		else $error("held result left over from a run");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q < VC_W'(MAX_VERTICES))
		else $error("kept edge count too large");

endmodule

>>> rtl/core/kmst_edge_store.sv
module kmst_edge_store (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [kmst_pkg::EIDX_W-1:0]   wr_addr,
	input  kmst_pkg::edge_rec_t           wr_data,
	input  logic [kmst_pkg::EIDX_W-1:0]   rd_addr,
	output kmst_pkg::edge_rec_t           rd_data
);
	import kmst_pkg::*;

	edge_rec_t mem [MAX_EDGES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

>>> rtl/core/kmst_parent_table.sv
module kmst_parent_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  kmst_pkg::pt_ctrl_t          ctrl,
	output logic                        root_s1,
	output logic [kmst_pkg::VID_W-1:0]  parent_s1
);
	import kmst_pkg::*;

	logic [VID_W-1:0]        mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] link_q;

	// entry without a link bit is a root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (ctrl.clear) begin
			link_q <= '0;
		end else if (ctrl.wr_en) begin
			link_q[ctrl.wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
		parent_s1 <= mem[ctrl.rd_addr];
		root_s1   <= !link_q[ctrl.rd_addr];
	end

endmodule

>>> test/tb_kruskal_minimum_spanning_tree.sv
`timescale 1ns / 100ps

class tree_scoreboard;
	kmst_pkg::tree_out_t pending_trees[$];
	logic [6:0]  vertex_count;
	logic [5:0]  store_src[$];
	logic [5:0]  store_dst[$];
	logic [31:0] store_w[$];
	bit          dropped;
	int          fail_count;
	int          runs_seen;
	int          edges_kept;

	function new();
		vertex_count = 7'd64;
		dropped = 0;
		fail_count = 0;
		runs_seen = 0;
		edges_kept = 0;
	endfunction

	function int active_vertices();
		if (vertex_count == 0)
			return 1;
		if (vertex_count > 64)
			return 64;
		return vertex_count;
	endfunction

	// note an accepted edge request and, on the final edge, work out the tree
	function void note_edge(kmst_pkg::edge_in_t e);
		int vc;
		int order[$];
		int parent[64];
		int kept;
		int j;
		int ra;
		int rb;
		int idx;
		logic signed [39:0] sum;
		kmst_pkg::tree_out_t t;
		vc = active_vertices();
		if (e.edge_source >= vc || e.edge_target >= vc || store_w.size() >= 256)
			dropped = 1;
		else begin
			store_src.push_back(e.edge_source);
			store_dst.push_back(e.edge_target);
			store_w.push_back(e.edge_weight);
		end
		if (!e.final_edge)
			return;
		// stable insertion sort on signed weight
		for (int i = 0; i < store_w.size(); i++) begin
			j = order.size();
			while (j > 0 && $signed(store_w[i]) < $signed(store_w[order[j-1]]))
				j--;
			order.insert(j, i);
		end
		for (int v = 0; v < 64; v++)
			parent[v] = -1;
		kept = 0;
		sum = 0;
		for (int i = 0; i < order.size() && kept + 1 < vc; i++) begin
			idx = order[i];
			if (store_src[idx] >= vc || store_dst[idx] >= vc)
				continue;
			ra = store_src[idx];
			while (parent[ra] >= 0)
				ra = parent[ra];
			rb = store_dst[idx];
			while (parent[rb] >= 0)
				rb = parent[rb];
			if (ra == rb)
				continue;
			parent[ra] = rb;
			kept++;
			sum = sum + {{8{store_w[idx][31]}}, store_w[idx]};
			t = '0;
			t.tree_source = store_src[idx];
			t.tree_target = store_dst[idx];
			t.tree_weight = store_w[idx];
			t.running_total = sum;
			t.edge_present = 1;
			t.input_dropped = dropped;
			pending_trees.push_back(t);
		end
		if (kept == 0) begin
			t = '0;
			t.input_dropped = dropped;
			pending_trees.push_back(t);
		end
		pending_trees[pending_trees.size()-1].run_end = 1;
		edges_kept += kept;
		runs_seen++;
		store_src.delete();
		store_dst.delete();
		store_w.delete();
		dropped = 0;
	endfunction

	function void check_tree(kmst_pkg::tree_out_t got);
		kmst_pkg::tree_out_t want;
		if (pending_trees.size() == 0) begin
			$display("%0t: unexpected result %h", $time, got);
			fail_count++;
			return;
		end
		want = pending_trees.pop_front();
		if (got !== want) begin
			$display("%0t: mismatch expected %h actual %h", $time, want, got);
			fail_count++;
		end
	endfunction
endclass

module tb_kruskal_minimum_spanning_tree;
	import kmst_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	edge_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	tree_out_t out_data;
	logic      psel;
	logic      penable;
	logic      pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tree_scoreboard board;
	// random idling on either side until the quiet tail of the run
	bit idle_on;
	// long receiver hold-off requested by the stimulus
	bit hold_request;

	kruskal_minimum_spanning_tree DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		#4_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// register write: setup cycle then access cycle
	task automatic write_vertex_count(input logic [6:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_VERTEX_COUNT, 2'b00};
		pwdata <= {25'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.vertex_count = value;
	endtask

	// offer one edge request and hold it until accepted
	task automatic send_edge(input logic [5:0] s, input logic [5:0] t,
			input logic [31:0] w, input bit last);
		edge_in_t e;
		e.edge_source = s;
		e.edge_target = t;
		e.edge_weight = w;
		e.final_edge = last;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= e;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_edge(e);
		// valid stays high for the next request unless the graph is done
		if (last)
			in_valid <= 1'b0;
	endtask

	// wait until the tree is fully drained, then let the block settle
	task automatic wait_drained();
		while (board.pending_trees.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// a random graph with edge count set by the caller; mostly in range, weights often colliding
	task automatic send_graph(input int n, input int vmax);
		logic [31:0] w;
		logic [5:0] s;
		logic [5:0] t;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: w = $urandom;
				1: w = $urandom_range(0, 7) - 4;
				2: w = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom_range(0, 15))};
				default: w = $urandom_range(0, 100);
			endcase
			s = ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, vmax - 1));
			t = ($urandom_range(0, 15) == 0) ? 6'($urandom) : 6'($urandom_range(0, vmax - 1));
			send_edge(s, t, w, i == n - 1);
		end
	endtask

	// sample results on the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_tree(out_data);
	end

	initial begin
		int count;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				// long stall while the sender keeps offering edges
				out_ready <= 1'b0;
				count = 0;
				while (count < 300) begin
					@(posedge clk);
					count++;
				end
				hold_request = 0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 3) - 1) @(posedge clk);
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin
		int sent;
		int vc;
		board = new();
		idle_on = 1;
		hold_request = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset vertex count, weight extremes, equal weights, self loop
		send_edge(6'd0, 6'd63, 32'h7fffffff, 0);
		send_edge(6'd63, 6'd0, 32'h80000000, 0);
		send_edge(6'd5, 6'd5, 32'h80000000, 0);
		send_edge(6'd1, 6'd2, 32'd3, 0);
		send_edge(6'd2, 6'd3, 32'd3, 0);
		send_edge(6'd1, 6'd3, 32'd3, 1);
		wait_drained();
		// lone self loop gives the empty item
		send_edge(6'd7, 6'd7, 32'd9, 1);
		wait_drained();
		// small graph; bad vertex dropped, dropped final edge still starts the run
		write_vertex_count(7'd4);
		send_edge(6'd0, 6'd1, 32'hffffffff, 0);
		send_edge(6'd4, 6'd1, 32'd1, 0);
		send_edge(6'd2, 6'd3, 32'd0, 0);
		send_edge(6'd1, 6'd2, 32'd5, 0);
		send_edge(6'd3, 6'd63, 32'd2, 1);
		wait_drained();
		// zero acts as one vertex: nothing kept
		write_vertex_count(7'd0);
		send_edge(6'd0, 6'd0, 32'd1, 0);
		send_edge(6'd0, 6'd1, 32'd1, 1);
		wait_drained();
		// above the maximum acts as 64
		write_vertex_count(7'd127);
		send_edge(6'd62, 6'd63, 32'd4, 0);
		send_edge(6'd0, 6'd63, 32'd4, 1);
		wait_drained();
		// vertex count lowered while loading: stored edges now out of range are skipped
		write_vertex_count(7'd64);
		send_edge(6'd40, 6'd41, 32'd1, 0);
		send_edge(6'd0, 6'd1, 32'd2, 0);
		in_valid <= 1'b0;
		repeat (5) @(posedge clk);
		write_vertex_count(7'd8);
		send_edge(6'd1, 6'd2, 32'd3, 1);
		wait_drained();

		// store overflow: more edges than the store holds, on two vertices
		write_vertex_count(7'd2);
		idle_on = 0;
		for (int i = 0; i < 258; i++)
			send_edge(6'($urandom_range(0, 1)), 6'($urandom_range(0, 1)),
				$urandom, i == 257);
		wait_drained();
		idle_on = 1;

		// random graphs under several vertex counts
		sent = 0;
		while (sent < 190) begin
			case ($urandom_range(0, 4))
				0: vc = 2;
				1: vc = 64;
				default: vc = $urandom_range(1, 16);
			endcase
			if (sent > 100 && sent < 140) begin
				// receiver holds off while a second graph waits at the input
				vc = 64;
				write_vertex_count(7'(vc));
				hold_request = 1;
				send_graph(24, vc);
				sent += 24;
			end else
				write_vertex_count(7'(vc));
			if (sent > 150)
				idle_on = 0;
			count_graph(vc, sent);
			wait_drained();
		end
		repeat (50) @(posedge clk);
		$display("covered %0d runs with %0d kept tree edges, vertex counts 0 to 127",
			board.runs_seen, board.edges_kept);
		if (board.fail_count == 0 && board.pending_trees.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	task automatic count_graph(input int vc, inout int sent);
		int n;
		n = $urandom_range(1, 24);
		send_graph(n, vc);
		sent += n;
	endtask
endmodule

>>> sim.f
rtl/core/kmst_pkg.sv
rtl/core/kmst_edge_store.sv
rtl/core/kmst_parent_table.sv
rtl/core/kruskal_minimum_spanning_tree.sv
test/tb_kruskal_minimum_spanning_tree.sv
